/* src/gle_pkg.sv */
`default_nettype none
package gle_pkg;

  localparam int CORDIC_STEPS = 24;
  localparam int STEPS        = (CORDIC_STEPS > 32) ? 32 : CORDIC_STEPS;
  localparam int LANES        = 4;
  // fold + CORDIC stages + sign fix + five rotation stages
  localparam int LATENCY      = STEPS + 7;

  localparam int LANE_LON  = 0;
  localparam int LANE_LAT  = 1;
  localparam int LANE_HLON = 2;
  localparam int LANE_HLAT = 3;

  localparam logic [0:0] REG_HOME_LON = 1'b0;
  localparam logic [0:0] REG_HOME_LAT = 1'b1;

  localparam logic signed [32:0] PI_Q29      = 33'sd1686629713;
  localparam logic signed [32:0] HALF_PI_Q29 = 33'sd843314857;
  localparam logic signed [33:0] GAIN_Q30    = 34'sd652032874;
  localparam logic signed [30:0] OUT_LIMIT   = 31'sd835059712;
  localparam logic signed [15:0] EARTH_KM    = 16'sd6371;

  typedef logic signed [31:0] trig_val_t;

  typedef struct packed {
    trig_val_t s;
    trig_val_t c;
  } trig_t;

  function automatic logic signed [32:0] atan_q29(input int k);
    case (k)
      0:  return 33'sd421657428;
      1:  return 33'sd248918915;
      2:  return 33'sd131521918;
      3:  return 33'sd66762579;
      4:  return 33'sd33510843;
      5:  return 33'sd16771758;
      6:  return 33'sd8387925;
      7:  return 33'sd4194219;
      8:  return 33'sd2097141;
      9:  return 33'sd1048575;
      10: return 33'sd524288;
      11: return 33'sd262144;
      12: return 33'sd131072;
      13: return 33'sd65536;
      14: return 33'sd32768;
      15: return 33'sd16384;
      16: return 33'sd8192;
      17: return 33'sd4096;
      18: return 33'sd2048;
      19: return 33'sd1024;
      20: return 33'sd512;
      21: return 33'sd256;
      22: return 33'sd128;
      23: return 33'sd64;
      24: return 33'sd32;
      25: return 33'sd16;
      26: return 33'sd8;
      27: return 33'sd4;
      28: return 33'sd2;
      29: return 33'sd1;
      default: return 33'sd0;
    endcase
  endfunction

  // Q2.30 x Q2.30 -> Q2.30, round half up
  function automatic trig_val_t mulq(input trig_val_t a, input trig_val_t b);
    logic signed [63:0] p;
    p = 64'(a) * 64'(b) + 64'sd536870912;
    return p[61:30];
  endfunction

  // Q2.30 -> km * 2^16
  function automatic logic signed [30:0] to_km16(input trig_val_t q);
    logic signed [47:0] p;
    p = 48'(EARTH_KM) * 48'(q) + 48'sd8192;
    return p[44:14];
  endfunction

endpackage
`default_nettype wire

/* src/geodetic_to_local_enu_unit.sv */
`default_nettype none
// Geodetic to local east/north offset on a 6371 km sphere. One transaction is
// accepted per clock (busy stays low); each result appears on out_east and
// out_north with out_valid high for one cycle, after the fold stage, 24 CORDIC
// stages, sign fix and five multiply/sum stages. The
// receiver cannot stall. Home registers are sampled with each transaction;
// write them only when no transaction is in flight.
module geodetic_to_local_enu_unit (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic signed [31:0] in_longitude,
  input  wire logic signed [30:0] in_latitude,
  output logic                    out_valid,
  output logic signed [30:0]      out_east,
  output logic signed [30:0]      out_north,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [31:0]        cfg_data
);

  logic signed [31:0] home_lon_r;
  logic signed [30:0] home_lat_r;
  logic [gle_pkg::LANES-1:0][32:0] ang;
  logic cordic_valid;
  gle_pkg::trig_t [gle_pkg::LANES-1:0] trig;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      home_lon_r <= '0;
      home_lat_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        gle_pkg::REG_HOME_LON: home_lon_r <= cfg_data;
        gle_pkg::REG_HOME_LAT: home_lat_r <= cfg_data[30:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  always_comb begin
    ang[gle_pkg::LANE_LON]  = 33'(in_longitude);
    ang[gle_pkg::LANE_LAT]  = 33'(in_latitude);
    ang[gle_pkg::LANE_HLON] = 33'(home_lon_r);
    ang[gle_pkg::LANE_HLAT] = 33'(home_lat_r);
  end

  gle_cordic u_cordic (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (start && !busy),
    .ang_in    (ang),
    .valid_out (cordic_valid),
    .trig_out  (trig)
  );

  gle_rotate u_rotate (
    .clk       (clk),
    .rst_n     (rst_n),
    .valid_in  (cordic_valid),
    .trig_in   (trig),
    .valid_out (out_valid),
    .east      (out_east),
    .north     (out_north)
  );

endmodule
`default_nettype wire

/* src/gle_cordic.sv */
`default_nettype none
module gle_cordic (
  input  wire logic                                   clk,
  input  wire logic                                   rst_n,
  input  wire logic                                   valid_in,
  input  wire logic [gle_pkg::LANES-1:0][32:0]        ang_in,
  output logic                                        valid_out,
  output gle_pkg::trig_t [gle_pkg::LANES-1:0]         trig_out
);

  logic signed [33:0] x_r    [0:gle_pkg::STEPS][gle_pkg::LANES];
  logic signed [33:0] y_r    [0:gle_pkg::STEPS][gle_pkg::LANES];
  logic signed [32:0] z_r    [0:gle_pkg::STEPS][gle_pkg::LANES];
  logic               flip_r [0:gle_pkg::STEPS][gle_pkg::LANES];
  logic               valid_r [0:gle_pkg::STEPS];
  logic               valid_out_r;
  gle_pkg::trig_t [gle_pkg::LANES-1:0] trig_r;

  // fold into +-pi/2
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r[0] <= 1'b0;
    end else begin
      valid_r[0] <= valid_in;
    end
    for (int l = 0; l < gle_pkg::LANES; l++) begin
      x_r[0][l] <= gle_pkg::GAIN_Q30;
      y_r[0][l] <= '0;
      if ($signed(ang_in[l]) > gle_pkg::HALF_PI_Q29) begin
        z_r[0][l]    <= $signed(ang_in[l]) - gle_pkg::PI_Q29;
        flip_r[0][l] <= 1'b1;
      end else if ($signed(ang_in[l]) < -gle_pkg::HALF_PI_Q29) begin
        z_r[0][l]    <= $signed(ang_in[l]) + gle_pkg::PI_Q29;
        flip_r[0][l] <= 1'b1;
      end else begin
        z_r[0][l]    <= $signed(ang_in[l]);
        flip_r[0][l] <= 1'b0;
      end
    end
  end

  for (genvar i = 1; i <= gle_pkg::STEPS; i++) begin : g_stage
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        valid_r[i] <= 1'b0;
      end else begin
        valid_r[i] <= valid_r[i-1];
      end
      for (int l = 0; l < gle_pkg::LANES; l++) begin
        flip_r[i][l] <= flip_r[i-1][l];
        if (!z_r[i-1][l][32]) begin
          x_r[i][l] <= x_r[i-1][l] - (y_r[i-1][l] >>> (i-1));
          y_r[i][l] <= y_r[i-1][l] + (x_r[i-1][l] >>> (i-1));
          z_r[i][l] <= z_r[i-1][l] - gle_pkg::atan_q29(i-1);
        end else begin
          x_r[i][l] <= x_r[i-1][l] + (y_r[i-1][l] >>> (i-1));
          y_r[i][l] <= y_r[i-1][l] - (x_r[i-1][l] >>> (i-1));
          z_r[i][l] <= z_r[i-1][l] + gle_pkg::atan_q29(i-1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_out_r <= 1'b0;
    end else begin
      valid_out_r <= valid_r[gle_pkg::STEPS];
    end
    for (int l = 0; l < gle_pkg::LANES; l++) begin
      if (flip_r[gle_pkg::STEPS][l]) begin
        trig_r[l].s <= 32'(-y_r[gle_pkg::STEPS][l]);
        trig_r[l].c <= 32'(-x_r[gle_pkg::STEPS][l]);
      end else begin
        trig_r[l].s <= 32'(y_r[gle_pkg::STEPS][l]);
        trig_r[l].c <= 32'(x_r[gle_pkg::STEPS][l]);
      end
    end
  end

  assign valid_out = valid_out_r;
  assign trig_out  = trig_r;

endmodule
`default_nettype wire

/* src/gle_rotate.sv */
`default_nettype none
module gle_rotate (
  input  wire logic                                  clk,
  input  wire logic                                  rst_n,
  input  wire logic                                  valid_in,
  input  wire gle_pkg::trig_t [gle_pkg::LANES-1:0]   trig_in,
  output logic                                       valid_out,
  output logic signed [30:0]                         east,
  output logic signed [30:0]                         north
);

  typedef struct packed {
    gle_pkg::trig_val_t sl0;
    gle_pkg::trig_val_t cl0;
    gle_pkg::trig_val_t cp0;
    gle_pkg::trig_val_t a1;
    gle_pkg::trig_val_t a2;
  } coef_t;

  // stage A: trig products
  logic               va_r;
  gle_pkg::trig_val_t cpcl_r, cpsl_r, cpcl0_r, cpsl0_r, sp_r, sp0_r;
  coef_t              ca_r;
  // stage B: km scale
  logic               vb_r;
  logic signed [30:0] kx_r, ky_r, kz_r, kx0_r, ky0_r, kz0_r;
  coef_t              cb_r;
  // stage C: differences
  logic               vc_r;
  logic signed [31:0] dx_r, dy_r, dz_r;
  coef_t              cc_r;
  // stage D: products
  logic               vd_r;
  logic signed [63:0] pe1_r, pe2_r, pn1_r, pn2_r, pn3_r;
  // stage E: sum, round, saturate
  logic               ve_r;
  logic signed [30:0] east_r, north_r;
  logic signed [63:0] e_sum, n_sum;
  logic signed [33:0] e_rnd, n_rnd;

  function automatic logic signed [30:0] sat(input logic signed [33:0] v);
    if (v > 34'(gle_pkg::OUT_LIMIT)) return gle_pkg::OUT_LIMIT;
    if (v < -34'(gle_pkg::OUT_LIMIT)) return -gle_pkg::OUT_LIMIT;
    return v[30:0];
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      vc_r <= 1'b0;
      vd_r <= 1'b0;
      ve_r <= 1'b0;
    end else begin
      va_r <= valid_in;
      vb_r <= va_r;
      vc_r <= vb_r;
      vd_r <= vc_r;
      ve_r <= vd_r;
    end
  end

  always_ff @(posedge clk) begin
    cpcl_r  <= gle_pkg::mulq(trig_in[gle_pkg::LANE_LAT].c, trig_in[gle_pkg::LANE_LON].c);
    cpsl_r  <= gle_pkg::mulq(trig_in[gle_pkg::LANE_LAT].c, trig_in[gle_pkg::LANE_LON].s);
    cpcl0_r <= gle_pkg::mulq(trig_in[gle_pkg::LANE_HLAT].c, trig_in[gle_pkg::LANE_HLON].c);
    cpsl0_r <= gle_pkg::mulq(trig_in[gle_pkg::LANE_HLAT].c, trig_in[gle_pkg::LANE_HLON].s);
    sp_r    <= trig_in[gle_pkg::LANE_LAT].s;
    sp0_r   <= trig_in[gle_pkg::LANE_HLAT].s;
    ca_r.sl0 <= trig_in[gle_pkg::LANE_HLON].s;
    ca_r.cl0 <= trig_in[gle_pkg::LANE_HLON].c;
    ca_r.cp0 <= trig_in[gle_pkg::LANE_HLAT].c;
    ca_r.a1  <= gle_pkg::mulq(trig_in[gle_pkg::LANE_HLAT].s, trig_in[gle_pkg::LANE_HLON].c);
    ca_r.a2  <= gle_pkg::mulq(trig_in[gle_pkg::LANE_HLAT].s, trig_in[gle_pkg::LANE_HLON].s);

    kx_r  <= gle_pkg::to_km16(cpcl_r);
    ky_r  <= gle_pkg::to_km16(cpsl_r);
    kz_r  <= gle_pkg::to_km16(sp_r);
    kx0_r <= gle_pkg::to_km16(cpcl0_r);
    ky0_r <= gle_pkg::to_km16(cpsl0_r);
    kz0_r <= gle_pkg::to_km16(sp0_r);
    cb_r  <= ca_r;

    dx_r <= 32'(kx_r) - 32'(kx0_r);
    dy_r <= 32'(ky_r) - 32'(ky0_r);
    dz_r <= 32'(kz_r) - 32'(kz0_r);
    cc_r <= cb_r;

    pe1_r <= 64'(cc_r.sl0) * 64'(dx_r);
    pe2_r <= 64'(cc_r.cl0) * 64'(dy_r);
    pn1_r <= 64'(cc_r.a1)  * 64'(dx_r);
    pn2_r <= 64'(cc_r.a2)  * 64'(dy_r);
    pn3_r <= 64'(cc_r.cp0) * 64'(dz_r);

    east_r  <= sat(e_rnd);
    north_r <= sat(n_rnd);
  end

  always_comb begin
    e_sum = pe2_r - pe1_r + 64'sd536870912;
    n_sum = pn3_r - pn1_r - pn2_r + 64'sd536870912;
    e_rnd = e_sum[63:30];
    n_rnd = n_sum[63:30];
  end

  assign valid_out = ve_r;
  assign east      = east_r;
  assign north     = north_r;

endmodule
`default_nettype wire

/* src/gle_checker.sv */
`default_nettype none
module gle_props (
  input wire logic               clk,
  input wire logic               rst_n,
  input wire logic               start,
  input wire logic               busy,
  input wire logic               out_valid,
  input wire logic signed [30:0] out_east,
  input wire logic signed [30:0] out_north
);

  a_no_busy: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, gle_pkg::LATENCY))
    else $error("result without a transaction");

  a_east_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_east <= gle_pkg::OUT_LIMIT && out_east >= -gle_pkg::OUT_LIMIT))
    else $error("east out of range");

  a_north_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_north <= gle_pkg::OUT_LIMIT && out_north >= -gle_pkg::OUT_LIMIT))
    else $error("north out of range");

endmodule

bind geodetic_to_local_enu_unit gle_props u_gle_props (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_east  (out_east),
  .out_north (out_north)
);
`default_nettype wire

/* sim/gle_checker.sv */
module gle_checker (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  input  wire logic               busy,
  input  wire logic signed [31:0] in_longitude,
  input  wire logic signed [30:0] in_latitude,
  input  wire logic               out_valid,
  input  wire logic signed [30:0] out_east,
  input  wire logic signed [30:0] out_north,
  input  wire logic               cfg_we,
  input  wire logic [0:0]         cfg_index,
  input  wire logic [31:0]        cfg_data,
  output int                      fail_count,
  output int                      pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct {
    logic signed [30:0] east;
    logic signed [30:0] north;
  } offset_t;

  offset_t offset_q[$];
  logic signed [31:0] home_lon;
  logic signed [30:0] home_lat;

  localparam longint ATAN_TBL[32] = '{
    421657428, 248918915, 131521918, 66762579, 33510843, 16771758,
    8387925, 4194219, 2097141, 1048575, 524288, 262144, 131072, 65536,
    32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16,
    8, 4, 2, 1, 0, 0};

  function automatic longint round_shift(longint v, int s);
    return (v + (longint'(1) <<< (s - 1))) >>> s;
  endfunction

  function automatic void sin_cos(input longint ang, output longint s, output longint c);
    longint x, y, z, xs, ys;
    bit flip;
    x = 652032874;
    y = 0;
    z = ang;
    flip = 0;
    if (z > 843314857) begin
      z -= 1686629713; flip = 1;
    end else if (z < -843314857) begin
      z += 1686629713; flip = 1;
    end
    for (int i = 0; i < gle_pkg::STEPS; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (z >= 0) begin
        x -= ys; y += xs; z -= ATAN_TBL[i];
      end else begin
        x += ys; y -= xs; z += ATAN_TBL[i];
      end
    end
    if (flip) begin
      x = -x; y = -y;
    end
    s = y;
    c = x;
  endfunction

  function automatic longint prod_q30(longint a, longint b);
    return round_shift(a * b, 30);
  endfunction

  function automatic longint km16(longint q);
    return round_shift(6371 * q, 14);
  endfunction

  function automatic longint clamp_out(longint v);
    if (v > 835059712) return 835059712;
    if (v < -835059712) return -835059712;
    return v;
  endfunction

  function automatic offset_t predict_offset(longint lon, longint lat);
    longint sl, cl, sp, cp, sl0, cl0, sp0, cp0, dx, dy, dz, e, n;
    offset_t r;
    sin_cos(lon, sl, cl);
    sin_cos(lat, sp, cp);
    sin_cos(longint'(home_lon), sl0, cl0);
    sin_cos(longint'(home_lat), sp0, cp0);
    dx = km16(prod_q30(cp, cl)) - km16(prod_q30(cp0, cl0));
    dy = km16(prod_q30(cp, sl)) - km16(prod_q30(cp0, sl0));
    dz = km16(sp) - km16(sp0);
    e = -sl0 * dx + cl0 * dy;
    n = -prod_q30(sp0, cl0) * dx - prod_q30(sp0, sl0) * dy + cp0 * dz;
    r.east = 31'(clamp_out(round_shift(e, 30)));
    r.north = 31'(clamp_out(round_shift(n, 30)));
    return r;
  endfunction

  assign pending = offset_q.size();

  always @(posedge clk) begin
    offset_t exp_r;
    if (!rst_n) begin
      home_lon <= '0;
      home_lat <= '0;
      fail_count <= 0;
      offset_q.delete();
    end else begin
      if (out_valid) begin
        if (offset_q.size() == 0) begin
          $display("%0t: unexpected result east=%0d north=%0d", $time, out_east, out_north);
          fail_count <= fail_count + 1;
        end else begin
          exp_r = offset_q.pop_front();
          if (exp_r.east !== out_east || exp_r.north !== out_north) begin
            $display("%0t: expected east=%0d north=%0d, actual east=%0d north=%0d",
                     $time, exp_r.east, exp_r.north, out_east, out_north);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (start && !busy)
        offset_q.push_back(predict_offset(longint'(in_longitude), longint'(in_latitude)));
      if (cfg_we) begin
        if (cfg_index == gle_pkg::REG_HOME_LON) home_lon <= cfg_data;
        else if (cfg_index == gle_pkg::REG_HOME_LAT) home_lat <= cfg_data[30:0];
      end
    end
  end
endmodule

/* sim/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  logic clk = 0;
  logic rst_n = 0;
  logic start = 0;
  logic busy;
  logic signed [31:0] in_longitude = '0;
  logic signed [30:0] in_latitude = '0;
  logic out_valid;
  logic signed [30:0] out_east, out_north;
  logic cfg_we = 0;
  logic [0:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int fail_count, pending;
  int cycles = 0;
  int n_items = 0;

  always begin
    #4 clk = 1;
    #4 clk = 0;
  end

  geodetic_to_local_enu_unit dut (.*);
  gle_checker chk (.*);

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 200000) begin
      $display("timeout");
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  function automatic logic [31:0] pick_lon(int mode);
    case (mode)
      0: return 32'($urandom_range(0, 2 * 1686629713) - 1686629713);
      1: return $urandom();
      default: return 32'($urandom_range(0, 20000000) - 10000000);
    endcase
  endfunction

  function automatic logic [30:0] pick_lat(int mode);
    case (mode)
      0: return 31'($urandom_range(0, 2 * 843314857) - 843314857);
      1: return 31'($urandom());
      default: return 31'($urandom_range(0, 20000000) - 10000000);
    endcase
  endfunction

  task automatic send_fix(logic [31:0] lon, logic [30:0] lat, bit gaps);
    if (gaps && $urandom_range(0, 4) == 0) begin
      start <= 0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    start <= 1;
    in_longitude <= lon;
    in_latitude <= lat;
    @(posedge clk);
    while (busy) @(posedge clk);
    n_items++;
  endtask

  task automatic drain_pipe();
    start <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (gle_pkg::LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_home(logic [31:0] lon, logic [30:0] lat);
    cfg_we <= 1;
    cfg_index <= gle_pkg::REG_HOME_LON;
    cfg_data <= lon;
    @(posedge clk);
    cfg_index <= gle_pkg::REG_HOME_LAT;
    cfg_data <= {1'b0, lat};
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
  endtask

  localparam logic [31:0] LON_MAX = 32'sd1686629713;
  localparam logic [30:0] LAT_MAX = 31'sd843314857;

  initial begin
    logic [31:0] hl [6];
    logic [30:0] ht [6];
    hl = '{0, LON_MAX, -LON_MAX, 32'h7fffffff, 32'h80000000, 0};
    ht = '{0, LAT_MAX, -LAT_MAX, 31'h3fffffff, 31'h40000000, 0};
    repeat (5) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);
    send_fix(0, 0, 0);
    send_fix(LON_MAX, LAT_MAX, 0);
    send_fix(-LON_MAX, -LAT_MAX, 0);
    send_fix(LON_MAX, -LAT_MAX, 0);
    send_fix(32'h7fffffff, 31'h3fffffff, 0);
    send_fix(32'h80000000, 31'h40000000, 0);
    send_fix(32'hffffffff, 31'h7fffffff, 0);
    send_fix(32'sd843314858, 31'sd843314858, 0);
    send_fix(-32'sd843314858, -31'sd843314858, 0);
    send_fix(32'sd843314857, 31'sd100, 0);
    drain_pipe();
    for (int ph = 0; ph < 6; ph++) begin
      if (ph == 5) write_home(pick_lon(0), pick_lat(0));
      else write_home(hl[ph], ht[ph]);
      send_fix(0, 0, 0);
      send_fix(LON_MAX, LAT_MAX, 0);
      send_fix(-LON_MAX, -LAT_MAX, 0);
      for (int i = 0; i < 200; i++)
        send_fix(pick_lon($urandom_range(0, 3)), pick_lat($urandom_range(0, 3)), ph < 5);
      drain_pipe();
    end
    while (pending != 0) @(posedge clk);
    repeat (gle_pkg::LATENCY + 10) @(posedge clk);
    $display("Sent %0d fixes over 7 home settings, incl. extremes and out-of-range angles.",
             n_items);
    if (fail_count == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule

/* geodetic_to_local_enu_unit.f */
src/gle_pkg.sv
src/gle_cordic.sv
src/gle_rotate.sv
src/geodetic_to_local_enu_unit.sv
src/gle_checker.sv
sim/gle_checker.sv
sim/tb_top.sv
